// ----- sv/hng_pkg.sv -----
// Shared types and constants of the height-map normal generator.
// Depends on nothing; used by hng_ctrl, hng_datapath and the top level.
package hng_pkg;

   // Line store geometry.
   localparam int MAX_WIDTH   = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int FW_W        = 11;
   localparam int FLAT_RADIUS = 7;
   localparam int FLAT_R2     = FLAT_RADIUS * FLAT_RADIUS;

   // Arithmetic widths.
   localparam int H_W    = 24;
   localparam int SQ_W   = 2 * H_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int ROOT_W = SUM_W / 2;
   localparam int RREM_W = ROOT_W + 2;
   localparam int DIV_W  = ROOT_W + 1;
   localparam int Q_W    = 16;
   localparam int OUT_W  = 16;
   localparam int CSR_W  = 24;
   localparam int CSR_IX_W = 3;

   // Sequencer step counts.
   localparam int SQ_STEPS   = 4;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = Q_W;
   localparam int CNT_W      = 5;

   // Register indexes.
   localparam logic [CSR_IX_W-1:0] CSR_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_IX_W-1:0] CSR_HEIGHT_SCALE  = 3'd1;
   localparam logic [CSR_IX_W-1:0] CSR_GRID_SPACING  = 3'd2;
   localparam logic [CSR_IX_W-1:0] CSR_FLAT_ENABLE   = 3'd3;
   localparam logic [CSR_IX_W-1:0] CSR_FLAT_CENTER_X = 3'd4;
   localparam logic [CSR_IX_W-1:0] CSR_FLAT_CENTER_Y = 3'd5;
   localparam logic [CSR_IX_W-1:0] CSR_FLAT_HEIGHT   = 3'd6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       update;
      logic       sq_en;
      logic [1:0] sq_sel;
      logic       root_init;
      logic       root_step;
      logic       div_init;
      logic       div_step;
      logic       finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit;
      logic out_free;
   } status_type;

endpackage

// ----- sv/hng_ctrl.sv -----
// Sequencing controller of the height-map normal generator.
// Depends on hng_pkg for the command and status types.
module hng_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hng_pkg::status_type status,
   output hng_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;
   localparam logic [2:0] ST_SQ     = 3'd2;
   localparam logic [2:0] ST_RINIT  = 3'd3;
   localparam logic [2:0] ST_ROOT   = 3'd4;
   localparam logic [2:0] ST_DINIT  = 3'd5;
   localparam logic [2:0] ST_DIV    = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic [hng_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // Only the idle state takes a new transaction.
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            cnt_in     = '0;
            state_in   = status.emit ? ST_SQ : ST_IDLE;
         end
         ST_SQ: begin
            cmd.sq_en  = 1'b1;
            cmd.sq_sel = cnt_ff[1:0];
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == hng_pkg::CNT_W'(hng_pkg::SQ_STEPS - 1)) begin
               state_in = ST_RINIT;
            end
         end
         ST_RINIT: begin
            cmd.root_init = 1'b1;
            cnt_in        = '0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == hng_pkg::CNT_W'(hng_pkg::ROOT_STEPS - 1)) begin
               state_in = ST_DINIT;
            end
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == hng_pkg::CNT_W'(hng_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- sv/hng_datapath.sv -----
// Datapath of the height-map normal generator: registers, line stores, window,
// squaring, bit-serial square root, three radix-2 dividers and result register.
// Depends on hng_pkg for constants and the command and status types.
module hng_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [hng_pkg::CSR_IX_W-1:0]        csr_index,
   input  logic [hng_pkg::CSR_W-1:0]           csr_data,
   input  logic [7:0]                          req_height_sample,
   input  logic                                req_start_of_frame,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [hng_pkg::OUT_W-1:0]    rsp_normal_x,
   output logic signed [hng_pkg::OUT_W-1:0]    rsp_normal_y,
   output logic signed [hng_pkg::OUT_W-1:0]    rsp_normal_z,
   output logic [hng_pkg::COL_W-1:0]           rsp_pixel_column,
   output logic [hng_pkg::COL_W-1:0]           rsp_pixel_row,
   input  hng_pkg::cmd_type                    cmd,
   output hng_pkg::status_type                 status
);

   localparam int COL_W  = hng_pkg::COL_W;
   localparam int FW_W   = hng_pkg::FW_W;
   localparam int H_W    = hng_pkg::H_W;
   localparam int SQ_W   = hng_pkg::SQ_W;
   localparam int SUM_W  = hng_pkg::SUM_W;
   localparam int ROOT_W = hng_pkg::ROOT_W;
   localparam int RREM_W = hng_pkg::RREM_W;
   localparam int DIV_W  = hng_pkg::DIV_W;
   localparam int Q_W    = hng_pkg::Q_W;
   localparam int OUT_W  = hng_pkg::OUT_W;

   // Configuration registers.
   logic [FW_W-1:0]  frame_width_ff;
   logic [15:0]      height_scale_ff;
   logic [H_W-1:0]   grid_spacing_ff;
   logic             flat_enable_ff;
   logic [COL_W-1:0] flat_center_x_ff;
   logic [COL_W-1:0] flat_center_y_ff;
   logic [H_W-1:0]   flat_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FW_W'(hng_pkg::MAX_WIDTH);
         height_scale_ff  <= 16'd4096;
         grid_spacing_ff  <= H_W'(4096);
         flat_enable_ff   <= 1'b0;
         flat_center_x_ff <= COL_W'(512);
         flat_center_y_ff <= COL_W'(512);
         flat_height_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            hng_pkg::CSR_FRAME_WIDTH:   frame_width_ff   <= csr_data[FW_W-1:0];
            hng_pkg::CSR_HEIGHT_SCALE:  height_scale_ff  <= csr_data[15:0];
            hng_pkg::CSR_GRID_SPACING:  grid_spacing_ff  <= csr_data[H_W-1:0];
            hng_pkg::CSR_FLAT_ENABLE:   flat_enable_ff   <= csr_data[0];
            hng_pkg::CSR_FLAT_CENTER_X: flat_center_x_ff <= csr_data[COL_W-1:0];
            hng_pkg::CSR_FLAT_CENTER_Y: flat_center_y_ff <= csr_data[COL_W-1:0];
            hng_pkg::CSR_FLAT_HEIGHT:   flat_height_ff   <= csr_data[H_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective row width, clamped to the supported range.
   logic [FW_W-1:0] width_eff;
   always_comb begin
      if (frame_width_ff < FW_W'(3)) begin
         width_eff = FW_W'(3);
      end else if (frame_width_ff > FW_W'(hng_pkg::MAX_WIDTH)) begin
         width_eff = FW_W'(hng_pkg::MAX_WIDTH);
      end else begin
         width_eff = frame_width_ff;
      end
   end

   // Raster position counters and the position of the current sample.
   logic [COL_W-1:0] col_ff, row_ff;
   logic [COL_W-1:0] col_cur_ff, row_cur_ff;
   logic [7:0]       sample_ff;
   logic [COL_W-1:0] col_sel, row_sel;

   always_comb begin
      col_sel = req_start_of_frame ? '0 : col_ff;
      row_sel = req_start_of_frame ? '0 : row_ff;
      if ({1'b0, col_sel} >= width_eff) begin
         col_sel = '0;
      end
   end

   // Line stores, read on acceptance and written back during the update.
   logic [H_W-1:0] above_mem  [hng_pkg::MAX_WIDTH];
   logic [H_W-1:0] centre_mem [hng_pkg::MAX_WIDTH];
   logic [H_W-1:0] above_rd_ff, centre_rd_ff;
   logic [H_W-1:0] h_val;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         above_rd_ff  <= above_mem[col_sel];
         centre_rd_ff <= centre_mem[col_sel];
      end
      if (cmd.update) begin
         above_mem[col_cur_ff]  <= centre_rd_ff;
         centre_mem[col_cur_ff] <= h_val;
      end
   end

   // Scaled height with the landing circle applied.
   logic [H_W-1:0]           h_scaled;
   logic signed [COL_W:0]    ddx, ddy;
   logic signed [2*COL_W+1:0] dist2;

   always_comb begin
      h_scaled = sample_ff * height_scale_ff;
      ddx      = $signed({1'b0, col_cur_ff}) - $signed({1'b0, flat_center_x_ff});
      ddy      = $signed({1'b0, row_cur_ff}) - $signed({1'b0, flat_center_y_ff});
      dist2    = ddx * ddx + ddy * ddy;
      if (flat_enable_ff && dist2 <= (2*COL_W+2)'(hng_pkg::FLAT_R2)) begin
         h_val = flat_height_ff;
      end else begin
         h_val = h_scaled;
      end
   end

   // Sample window and gradient magnitudes.
   logic [H_W-1:0] prev_ff, mid_left1_ff, mid_left2_ff, top_left1_ff;
   logic [H_W-1:0] dx_mag_ff, dz_mag_ff;
   logic           dx_pos_ff, dz_pos_ff;
   logic [COL_W-1:0] px_col_ff, px_row_ff;
   logic [FW_W-1:0]  col_next;

   assign col_next = {1'b0, col_cur_ff} + 1'b1;
   assign status.emit = (col_cur_ff >= COL_W'(2)) && (row_cur_ff >= COL_W'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         prev_ff      <= '0;
         mid_left1_ff <= '0;
         mid_left2_ff <= '0;
         top_left1_ff <= '0;
      end else begin
         if (cmd.accept) begin
            sample_ff  <= req_height_sample;
            col_cur_ff <= col_sel;
            row_cur_ff <= row_sel;
         end
         if (cmd.update) begin
            // Central differences use the window before it moves on.
            dx_pos_ff    <= centre_rd_ff > mid_left2_ff;
            dx_mag_ff    <= (centre_rd_ff > mid_left2_ff) ? centre_rd_ff - mid_left2_ff
                                                          : mid_left2_ff - centre_rd_ff;
            dz_pos_ff    <= prev_ff > top_left1_ff;
            dz_mag_ff    <= (prev_ff > top_left1_ff) ? prev_ff - top_left1_ff
                                                     : top_left1_ff - prev_ff;
            px_col_ff    <= col_cur_ff - 1'b1;
            px_row_ff    <= row_cur_ff - 1'b1;
            mid_left2_ff <= mid_left1_ff;
            mid_left1_ff <= centre_rd_ff;
            top_left1_ff <= above_rd_ff;
            prev_ff      <= h_val;
            if (col_next >= width_eff) begin
               col_ff <= '0;
               row_ff <= row_cur_ff + 1'b1;
            end else begin
               col_ff <= col_next[COL_W-1:0];
               row_ff <= row_cur_ff;
            end
         end
      end
   end

   // Sum of squares through one shared multiplier.
   logic [H_W-1:0]   sq_op;
   logic [SQ_W-1:0]  prod_ff;
   logic [SUM_W-1:0] acc_ff;

   always_comb begin
      case (cmd.sq_sel)
         2'd0:    sq_op = dx_mag_ff;
         2'd1:    sq_op = dz_mag_ff;
         default: sq_op = grid_spacing_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_en) begin
         prod_ff <= sq_op * sq_op;
         if (cmd.sq_sel == 2'd0) begin
            acc_ff <= '0;
         end else begin
            acc_ff <= acc_ff + {2'b00, prod_ff};
         end
      end
   end

   // Square root, two radicand bits per cycle.
   logic [SUM_W-1:0]  rad_ff;
   logic [RREM_W-1:0] rrem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [RREM_W+1:0] rrem_sh, rtrial;

   assign rrem_sh = {rrem_ff, rad_ff[SUM_W-1 -: 2]};
   assign rtrial  = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         rad_ff  <= acc_ff;
         rrem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[SUM_W-3:0], 2'b00};
         if (rrem_sh >= rtrial) begin
            rrem_ff <= RREM_W'(rrem_sh - rtrial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rrem_ff <= rrem_sh[RREM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Three restoring dividers: (mag * 65536 + root) / (2 * root).
   logic [DIV_W-1:0] divisor;
   logic [Q_W-1:0]   low_ff;
   logic [DIV_W-1:0] drem_ff [3];
   logic [Q_W-1:0]   quot_ff [3];
   logic [H_W-1:0]   mag     [3];
   logic [DIV_W:0]   drem_sh [3];

   assign divisor = {root_ff, 1'b0};
   assign mag[0]  = dx_mag_ff;
   assign mag[1]  = grid_spacing_ff;
   assign mag[2]  = dz_mag_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         drem_sh[i] = {drem_ff[i], low_ff[Q_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         low_ff <= root_ff[Q_W-1:0];
         for (int i = 0; i < 3; i++) begin
            drem_ff[i] <= DIV_W'(mag[i]) + DIV_W'(root_ff[ROOT_W-1:Q_W]);
            quot_ff[i] <= '0;
         end
      end else if (cmd.div_step) begin
         low_ff <= {low_ff[Q_W-2:0], 1'b0};
         for (int i = 0; i < 3; i++) begin
            if (drem_sh[i] >= {1'b0, divisor}) begin
               drem_ff[i] <= DIV_W'(drem_sh[i] - {1'b0, divisor});
               quot_ff[i] <= {quot_ff[i][Q_W-2:0], 1'b1};
            end else begin
               drem_ff[i] <= drem_sh[i][DIV_W-1:0];
               quot_ff[i] <= {quot_ff[i][Q_W-2:0], 1'b0};
            end
         end
      end
   end

   // Sign and saturation of each component.
   function automatic logic [OUT_W-1:0] fmt_comp(input logic neg, input logic [Q_W-1:0] q);
      logic [OUT_W-1:0] res;
      if (neg) begin
         res = OUT_W'(-q);
      end else if (q > Q_W'(32767)) begin
         res = OUT_W'(32767);
      end else begin
         res = q;
      end
      return res;
   endfunction

   // Result register; the next transaction may be taken while it waits.
   logic rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_pixel_column <= px_col_ff;
         rsp_pixel_row    <= px_row_ff;
         if (root_ff == '0) begin
            // A zero-length vector points straight up.
            rsp_normal_x <= '0;
            rsp_normal_y <= OUT_W'(32767);
            rsp_normal_z <= '0;
         end else begin
            rsp_normal_x <= fmt_comp(dx_pos_ff, quot_ff[0]);
            rsp_normal_y <= fmt_comp(1'b0, quot_ff[1]);
            rsp_normal_z <= fmt_comp(dz_pos_ff, quot_ff[2]);
         end
      end
   end

endmodule

// ----- sv/heightmap_normal_generator.sv -----
// Top level of the height-map normal generator.
// Depends on hng_pkg, hng_ctrl and hng_datapath.
//
//   Channel  Ports                        Direction  Transaction
//   req      req_valid/req_stall/fields    in         one height byte
//   rsp      rsp_valid/rsp_stall/fields    out        one unit normal of an interior pixel
//   csr      csr_write/index/data          in         one register write
//
// A sample that completes an interior pixel occupies the block through squaring
// on one multiplier, 25 square-root steps and 16 steps of three parallel dividers;
// other samples pass only through acceptance and the line-store update.
// Reset is synchronous and active high; the line stores are not cleared.
// A held result stalls the next finished normal only, not the next input.
module heightmap_normal_generator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [hng_pkg::CSR_IX_W-1:0]     csr_index,
   input  logic [hng_pkg::CSR_W-1:0]        csr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_height_sample,
   input  logic                             req_start_of_frame,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [hng_pkg::OUT_W-1:0] rsp_normal_x,
   output logic signed [hng_pkg::OUT_W-1:0] rsp_normal_y,
   output logic signed [hng_pkg::OUT_W-1:0] rsp_normal_z,
   output logic [hng_pkg::COL_W-1:0]        rsp_pixel_column,
   output logic [hng_pkg::COL_W-1:0]        rsp_pixel_row
);

   hng_pkg::cmd_type    cmd;
   hng_pkg::status_type status;

   // Sequencer.
   hng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and storage.
   hng_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_height_sample  (req_height_sample),
      .req_start_of_frame (req_start_of_frame),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_normal_x       (rsp_normal_x),
      .rsp_normal_y       (rsp_normal_y),
      .rsp_normal_z       (rsp_normal_z),
      .rsp_pixel_column   (rsp_pixel_column),
      .rsp_pixel_row      (rsp_pixel_row),
      .cmd                (cmd),
      .status             (status)
   );

endmodule
